[rtl/core/sgcf_pkg.sv]
// Shared types, codes and defaults for the staggered ghost-cell fill block.
// Used by sgcf_seq, the top level and the checker; depends on nothing else.
package sgcf_pkg;

  localparam int MaxCellsDefault = 8192;
  localparam int WordBitsDefault = 32;

  // Word command kinds carried in s_tuser. The spare code behaves as a read.
  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_READ     = 2'd1;
  localparam logic [1:0] KIND_FILL     = 2'd2;
  localparam logic [1:0] KIND_READ_ALT = 2'd3;

  // Result status codes carried in m_tuser.
  localparam logic [1:0] STAT_WRITE = 2'd0;
  localparam logic [1:0] STAT_READ  = 2'd1;
  localparam logic [1:0] STAT_FILL  = 2'd2;

  // Per-face boundary modes.
  localparam logic [1:0] MODE_MIRROR   = 2'd0;
  localparam logic [1:0] MODE_COPY     = 2'd1;
  localparam logic [1:0] MODE_ZERO     = 2'd2;
  localparam logic [1:0] MODE_PERIODIC = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_STAGGER = 3'd0;
  localparam logic [2:0] REG_SIZE_X  = 3'd1;
  localparam logic [2:0] REG_SIZE_Y  = 3'd2;
  localparam logic [2:0] REG_SIZE_Z  = 3'd3;
  localparam logic [2:0] REG_GHOST   = 3'd4;
  localparam logic [2:0] REG_ENABLE  = 3'd5;
  localparam logic [2:0] REG_MODES   = 3'd6;

  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = 12;

  typedef struct packed {
    logic [1:0]  stagger;
    logic [4:0]  size_x;
    logic [4:0]  size_y;
    logic [4:0]  size_z;
    logic [2:0]  ghost;
    logic [5:0]  enable;
    logic [11:0] modes;
  } cfg_t;

  // Memory request from the fill sequencer.
  typedef struct packed {
    logic rd;
    logic wr;
    logic zero;
    logic done;
  } seq_req_t;

endpackage

[rtl/core/sgcf_store.sv]
// Field word memory: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
module sgcf_store #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/sgcf_seq.sv]
// Ghost-fill sequencer: walks faces, layers and face cells, issuing a
// source read and a target write per copied cell, or only a target write per zeroed cell. Depends on sgcf_pkg.
module sgcf_seq
  import sgcf_pkg::*;
#(
  parameter int ADDR_BITS = 13
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  cfg_t                 cfg,
  output seq_req_t             req,
  output logic [ADDR_BITS-1:0] addr
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FACE  = 6'b000010,
    S_LAYER = 6'b000100,
    S_RD    = 6'b001000,
    S_WR    = 6'b010000,
    S_DONE  = 6'b100000
  } seq_state_t;

  seq_state_t state;
  logic [2:0]  face;
  logic [2:0]  layer;
  logic [4:0]  u;
  logic [4:0]  v;
  logic [4:0]  tc;
  logic [4:0]  sc;
  logic [1:0]  mode;
  logic [5:0]  dim0;
  logic [5:0]  dim1;
  logic [5:0]  dim2;
  logic [11:0] d01;

  logic [1:0]  stg;
  logic [1:0]  face_d;
  logic [5:0]  dim_d;
  logic [5:0]  dim_o1;
  logic [5:0]  dim_o2;
  logic [1:0]  face_mode;
  logic signed [7:0] end_s;
  logic signed [7:0] g_s;
  logic signed [7:0] gw_s;
  logic signed [7:0] tc_s;
  logic signed [7:0] sc_s;
  logic        layer_ok;
  logic [4:0]  lay;
  logic [4:0]  c0;
  logic [4:0]  c1;
  logic [4:0]  c2;
  logic [16:0] addr_sum;
  logic        v_last;
  logic        u_last;

  assign stg    = (cfg.stagger == 2'd3) ? 2'd2 : cfg.stagger;
  assign face_d = face[2:1];

  always_comb begin
    case (face_d)
      2'd0: begin
        dim_d  = dim0;
        dim_o1 = dim1;
        dim_o2 = dim2;
      end
      2'd1: begin
        dim_d  = dim1;
        dim_o1 = dim0;
        dim_o2 = dim2;
      end
      default: begin
        dim_d  = dim2;
        dim_o1 = dim0;
        dim_o2 = dim1;
      end
    endcase
  end

  assign face_mode = cfg.modes[{face, 1'b0} +: 2];
  assign gw_s  = $signed({5'd0, cfg.ghost});
  assign g_s   = $signed({5'd0, layer});
  assign end_s = $signed({2'd0, dim_d}) - gw_s - 8'sd1;

  // Target and source coordinates of the current layer.
  always_comb begin
    if (!face[0]) begin
      tc_s = g_s;
      case (face_mode)
        MODE_MIRROR: sc_s = 8'sd2 * gw_s - 8'sd1 - g_s;
        MODE_COPY:   sc_s = gw_s;
        default:     sc_s = g_s + end_s - gw_s + 8'sd1;
      endcase
    end else begin
      tc_s = end_s + 8'sd1 + g_s;
      case (face_mode)
        MODE_MIRROR: sc_s = end_s - g_s;
        MODE_COPY:   sc_s = end_s;
        default:     sc_s = gw_s + g_s;
      endcase
    end
  end

  assign layer_ok = (tc_s >= 8'sd0) && (tc_s < $signed({2'd0, dim_d}))
                 && ((face_mode == MODE_ZERO)
                     || ((sc_s >= 8'sd0) && (sc_s < $signed({2'd0, dim_d}))))
                 && (dim_o1 != 6'd0) && (dim_o2 != 6'd0);

  assign lay = (state == S_RD) ? sc : tc;

  always_comb begin
    case (face_d)
      2'd0: begin
        c0 = lay;
        c1 = u;
        c2 = v;
      end
      2'd1: begin
        c0 = u;
        c1 = lay;
        c2 = v;
      end
      default: begin
        c0 = u;
        c1 = v;
        c2 = lay;
      end
    endcase
  end

  assign addr_sum = 17'(c0) + 17'(c1) * 17'(dim0) + 17'(c2) * 17'(d01);
  assign addr     = addr_sum[ADDR_BITS-1:0];

  assign v_last = ({1'b0, v} == dim_o2 - 6'd1);
  assign u_last = ({1'b0, u} == dim_o1 - 6'd1);

  assign req.rd   = (state == S_RD);
  assign req.wr   = (state == S_WR);
  assign req.zero = (mode == MODE_ZERO);
  assign req.done = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            face  <= 3'd0;
            dim0  <= {1'b0, cfg.size_x} + ((stg != 2'd0) ? 6'd1 : 6'd0);
            dim1  <= {1'b0, cfg.size_y} + ((stg != 2'd1) ? 6'd1 : 6'd0);
            dim2  <= {1'b0, cfg.size_z} + ((stg != 2'd2) ? 6'd1 : 6'd0);
            state <= S_FACE;
          end
        end
        S_FACE: begin
          d01 <= dim0 * dim1;
          if (face == 3'd6) begin
            state <= S_DONE;
          end else if (cfg.enable[face] && (cfg.ghost != 3'd0)) begin
            layer <= 3'd0;
            mode  <= face_mode;
            state <= S_LAYER;
          end else begin
            face <= face + 3'd1;
          end
        end
        S_LAYER: begin
          if (layer == cfg.ghost) begin
            face  <= face + 3'd1;
            state <= S_FACE;
          end else if (layer_ok) begin
            tc    <= tc_s[4:0];
            sc    <= sc_s[4:0];
            u     <= 5'd0;
            v     <= 5'd0;
            state <= (mode == MODE_ZERO) ? S_WR : S_RD;
          end else begin
            layer <= layer + 3'd1;
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (v_last) begin
            v <= 5'd0;
            if (u_last) begin
              layer <= layer + 3'd1;
              state <= S_LAYER;
            end else begin
              u     <= u + 5'd1;
              state <= (mode == MODE_ZERO) ? S_WR : S_RD;
            end
          end else begin
            v     <= v + 5'd1;
            state <= (mode == MODE_ZERO) ? S_WR : S_RD;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/staggered_ghost_cell_fill.sv]
// Top level of the staggered ghost-cell fill block: stream ports, config
// registers, result register. Depends on sgcf_pkg, sgcf_store, sgcf_seq.
//
// Usage: each input word on the s_ channel is one command chosen by s_tuser:
// write a cell, read a cell, or run a ghost fill over all enabled faces.
// Every command returns exactly one result word on the m_ channel, with the
// status in m_tuser and the read data (zero for writes and fills) in m_tdata.
// After a write, the next word is taken in the following cycle only
// if the write result is accepted in that same cycle. A read passes through
// the T_RD state because the field memory has registered read data. A fill
// walks every ghost cell of every enabled face: a source read, then a target
// write, per copied cell, and a target write alone per zeroed cell.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it only while idle (not enforced).
// Reset restores the register defaults and clears the handshake state; the
// field memory keeps no reset, so only cells written or filled may be read.
// When the receiver stalls, the result holds on m_tdata/m_tuser and no new
// command is taken until it is accepted or being accepted.
// MAX_CELLS must be a power of two; addresses wrap modulo MAX_CELLS.
module staggered_ghost_cell_fill
  import sgcf_pkg::*;
#(
  parameter int MAX_CELLS = MaxCellsDefault,
  parameter int WORD_BITS = WordBitsDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CfgIndexBits-1:0] cfg_index,
  input  logic [CfgDataBits-1:0]  cfg_data,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [47:0]             s_tdata,   // cell_address[12:0], cell_value[44:13], zeros
  input  logic [1:0]              s_tuser,   // kind[1:0]
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [31:0]             m_tdata,   // read_value[31:0]
  output logic [1:0]              m_tuser    // status[1:0]
);

  localparam int AddrBits = $clog2(MAX_CELLS);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_RD   = 3'b010,
    T_FILL = 3'b100
  } top_state_t;

  top_state_t state;
  cfg_t       cfg;
  seq_req_t   req;

  logic [AddrBits-1:0]  seq_addr;
  logic [AddrBits-1:0]  cmd_addr;
  logic [WORD_BITS-1:0] cmd_wdata;
  logic [WORD_BITS-1:0] rdata;
  logic                 accept;
  logic                 mem_we;
  logic                 mem_re;
  logic [AddrBits-1:0]  mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stagger <= 2'd0;
      cfg.size_x  <= 5'd16;
      cfg.size_y  <= 5'd16;
      cfg.size_z  <= 5'd16;
      cfg.ghost   <= 3'd3;
      cfg.enable  <= 6'd0;
      cfg.modes   <= 12'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STAGGER: cfg.stagger <= cfg_data[1:0];
        REG_SIZE_X:  cfg.size_x  <= cfg_data[4:0];
        REG_SIZE_Y:  cfg.size_y  <= cfg_data[4:0];
        REG_SIZE_Z:  cfg.size_z  <= cfg_data[4:0];
        REG_GHOST:   cfg.ghost   <= cfg_data[2:0];
        REG_ENABLE:  cfg.enable  <= cfg_data[5:0];
        REG_MODES:   cfg.modes   <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  // A command is taken only when idle and the result slot is free or draining.
  assign s_tready  = (state == T_IDLE) && (!m_tvalid || m_tready);
  assign accept    = s_tvalid && s_tready;
  assign cmd_addr  = AddrBits'(s_tdata[12:0]);
  assign cmd_wdata = WORD_BITS'(s_tdata[44:13]);

  // The sequencer owns the memory while a fill runs; commands use it otherwise.
  assign mem_we    = (accept && (s_tuser == KIND_WRITE)) || req.wr;
  assign mem_re    = (accept && (s_tuser != KIND_WRITE) && (s_tuser != KIND_FILL))
                  || req.rd;
  assign mem_addr  = (state == T_FILL) ? seq_addr : cmd_addr;
  assign mem_wdata = (state == T_FILL) ? (req.zero ? '0 : rdata) : cmd_wdata;

  sgcf_store #(
    .DEPTH (MAX_CELLS),
    .WIDTH (WORD_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_addr),
    .rdata (rdata)
  );

  sgcf_seq #(
    .ADDR_BITS (AddrBits)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept && (s_tuser == KIND_FILL)),
    .cfg   (cfg),
    .req   (req),
    .addr  (seq_addr)
  );

  // Command state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= T_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept) begin
            if (s_tuser == KIND_WRITE) begin
              m_tvalid <= 1'b1;
              m_tdata  <= 32'd0;
              m_tuser  <= STAT_WRITE;
            end else if (s_tuser == KIND_FILL) begin
              state <= T_FILL;
            end else begin
              state <= T_RD;
            end
          end
        end
        T_RD: begin
          m_tvalid <= 1'b1;
          m_tdata  <= 32'(rdata);
          m_tuser  <= STAT_READ;
          state    <= T_IDLE;
        end
        T_FILL: begin
          if (req.done) begin
            m_tvalid <= 1'b1;
            m_tdata  <= 32'd0;
            m_tuser  <= STAT_FILL;
            state    <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/sgcf_checker.sv]
// Port-level checks for staggered_ghost_cell_fill and the bind that attaches
// them. Depends on sgcf_pkg and the top level's ports.
module sgcf_checker
  import sgcf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A result left waiting keeps its word.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // Only reads carry data.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_READ) |-> (m_tdata == 32'd0))
    else $error("non-read result carries data");

  // A write result shows in the cycle after the write is taken.
  a_wr: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_WRITE)
      |=> m_tvalid && (m_tuser == STAT_WRITE))
    else $error("write result missing");

  // No command is taken while a result stalls.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("command taken during stall");

  // Reset leaves no result pending once it is released.
  a_rst: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind staggered_ghost_cell_fill sgcf_checker u_sgcf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
